### rtl/core/keyframe_pose_interpolator_core_macros.svh
// Assertion macros shared by the keyframe pose interpolator RTL.
// No dependencies; each macro expects clk and arst_n in the using scope.
`ifndef KEYFRAME_POSE_INTERPOLATOR_CORE_MACROS_SVH
`define KEYFRAME_POSE_INTERPOLATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define KPI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kpi assertion failed");

// next-cycle implication, disabled during reset
`define KPI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kpi assertion failed");

`endif

### rtl/core/kpi_pkg.sv
// Package for the keyframe pose interpolator: sizes, codes, types.
// No dependencies.
`default_nettype none
package kpi_pkg;

	localparam int MOTIONS    = 8;
	localparam int KEYS       = 16;
	localparam int PARTS      = 16;
	localparam int FRAME_BITS = 10;
	localparam int NCOMP      = 6;
	localparam int VAL_W      = 24;

	localparam int POSE_DEPTH = MOTIONS * KEYS * PARTS * NCOMP;
	localparam int POSE_AW    = $clog2(POSE_DEPTH);
	localparam int DUR_DEPTH  = MOTIONS * KEYS;
	localparam int DUR_AW     = $clog2(DUR_DEPTH);
	localparam int REST_DEPTH = PARTS * NCOMP;
	localparam int REST_AW    = $clog2(REST_DEPTH);
	localparam int CNT_W      = $clog2(PARTS + 1);
	localparam int KCNT_W     = $clog2(KEYS + 1);

	// |(b - a) * t| stays below 2^(VAL_W + FRAME_BITS)
	localparam int MAG_W  = VAL_W + FRAME_BITS;
	localparam int PROD_W = MAG_W + 2;

	// first rotation component
	localparam int COMP_ROT = 3;

	localparam logic signed [VAL_W+3:0] PI_Q     = 28'sd3294199;
	localparam logic signed [VAL_W+3:0] TWO_PI_Q = 28'sd6588397;
	localparam logic signed [VAL_W+3:0] V_MAX    = 28'sd8388607;
	localparam logic signed [VAL_W+3:0] V_MIN    = -28'sd8388608;

	typedef enum logic [2:0] {
		KIND_KEY  = 3'd0,
		KIND_DUR  = 3'd1,
		KIND_HDR  = 3'd2,
		KIND_REST = 3'd3,
		KIND_SEL  = 3'd4,
		KIND_TICK = 3'd5
	} kpi_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DUR, ST_RDA, ST_RDB, ST_MUL, ST_DIVS, ST_DIV, ST_OUT
	} kpi_state_t;

	typedef struct packed {
		logic                  start;
		logic [MAG_W-1:0]      dividend;
		logic [FRAME_BITS-1:0] divisor;
	} kpi_div_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] quotient;
	} kpi_div_rsp_t;

endpackage
`default_nettype wire

### rtl/core/kpi_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module kpi_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/kpi_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on kpi_pkg.
`default_nettype none
module kpi_div import kpi_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire kpi_div_req_t req,
	output kpi_div_rsp_t      rsp
);

	localparam int STEP_W = $clog2(MAG_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [FRAME_BITS-1:0] rem_q;
	logic [FRAME_BITS-1:0] dvs_q;
	logic [MAG_W-1:0]      quo_q;
	logic [FRAME_BITS:0]   trial;
	logic                  ge;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(MAG_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_W-2:0], ge};
			rem_q <= ge ? FRAME_BITS'(trial - {1'b0, dvs_q}) : trial[FRAME_BITS-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

### rtl/core/keyframe_pose_interpolator_core.sv
// Keyframe pose interpolator top level: request decode, tick sequencer, arithmetic.
// Depends on kpi_pkg, kpi_ram, kpi_div and the core macros header.
//
// Write requests (key component, key duration, motion header, rest component,
// motion select) take effect on acceptance. A tick reads the active key's duration,
// advances the key timing, then walks every part in use and every component,
// reading the current and next key poses from the pose memory one after the
// other. Each component waits on the one-bit-per-cycle divider that forms
// (next - key) * t / F. New requests are held off by in_stall until the last
// result of a tick sits in the output register.
// No clearing pass after reset: rest pose entries carry valid bits.
`default_nettype none
`include "keyframe_pose_interpolator_core_macros.svh"
module keyframe_pose_interpolator_core import kpi_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// request channel
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [2:0]              kind,
	input  wire logic [2:0]              motion,
	input  wire logic [3:0]              key,
	input  wire logic [3:0]              part,
	input  wire logic [2:0]              component,
	input  wire logic signed [VAL_W-1:0] value,
	input  wire logic                    loop_flag,
	// result channel
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [3:0]                   part_index,
	output logic signed [VAL_W-1:0]      pos_x,
	output logic signed [VAL_W-1:0]      pos_y,
	output logic signed [VAL_W-1:0]      pos_z,
	output logic signed [VAL_W-1:0]      rot_x,
	output logic signed [VAL_W-1:0]      rot_y,
	output logic signed [VAL_W-1:0]      rot_z,
	output logic                         last,
	output logic                         finished,
	// configuration
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [2:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	// ---------------- configuration register ----------------
	logic [4:0] part_count_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {27'd0, part_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			part_count_q <= pwdata[4:0];
		end
	end

	// ---------------- control state ----------------
	kpi_state_t state_q, state_d;

	logic [2:0]            act_motion_q;
	logic [3:0]            act_key_q;
	logic [FRAME_BITS-1:0] tick_q;
	logic                  done_q;
	logic [KCNT_W-1:0]     kcount_q [MOTIONS];
	logic                  loop_q   [MOTIONS];
	logic [REST_DEPTH-1:0] rest_vld_q;

	// tick snapshot
	logic [2:0]            m_s1;
	logic [3:0]            k_s1;
	logic [3:0]            nk_s1;
	logic                  is_last_s1;
	logic [CNT_W-1:0]      cnt_s1;
	logic [FRAME_BITS-1:0] f_q;
	logic [FRAME_BITS-1:0] t_q;

	// walk indexes
	logic [3:0] p_q;
	logic [2:0] c_q;

	logic accept;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	logic in_range_mk, in_range_pc;
	assign in_range_mk = (int'(motion) < MOTIONS) && (int'(key) < KEYS);
	assign in_range_pc = (int'(part) < PARTS) && (int'(component) < NCOMP);

	// ---------------- memories ----------------
	logic                  pose_we;
	logic [POSE_AW-1:0]    pose_waddr, pose_raddr;
	logic [VAL_W-1:0]      pose_rdata;
	logic                  dur_we;
	logic [DUR_AW-1:0]     dur_waddr, dur_raddr;
	logic [FRAME_BITS-1:0] dur_rdata;
	logic                  rest_we;
	logic [REST_AW-1:0]    rest_waddr, rest_raddr;
	logic [VAL_W-1:0]      rest_rdata;

	function automatic logic [POSE_AW-1:0] pose_addr(input logic [2:0] m, input logic [3:0] k,
		input logic [3:0] p, input logic [2:0] c);
		logic [POSE_AW-1:0] row;
		row = POSE_AW'(m) * POSE_AW'(KEYS * PARTS) + POSE_AW'(k) * POSE_AW'(PARTS)
			+ POSE_AW'(p);
		return row * POSE_AW'(NCOMP) + POSE_AW'(c);
	endfunction

	assign pose_we    = accept && kpi_kind_t'(kind) == KIND_KEY && in_range_mk && in_range_pc;
	assign pose_waddr = pose_addr(motion, key, part, component);
	assign pose_raddr = (state_q == ST_RDB) ? pose_addr(m_s1, nk_s1, p_q, c_q)
		: pose_addr(m_s1, k_s1, p_q, c_q);

	assign dur_we    = accept && kpi_kind_t'(kind) == KIND_DUR && in_range_mk;
	assign dur_waddr = DUR_AW'(motion) * DUR_AW'(KEYS) + DUR_AW'(key);
	assign dur_raddr = DUR_AW'(act_motion_q) * DUR_AW'(KEYS) + DUR_AW'(act_key_q);

	assign rest_we    = accept && kpi_kind_t'(kind) == KIND_REST && in_range_pc;
	assign rest_waddr = REST_AW'(part) * REST_AW'(NCOMP) + REST_AW'(component);
	assign rest_raddr = REST_AW'(p_q) * REST_AW'(NCOMP) + REST_AW'(c_q);

	kpi_ram #(.WIDTH(VAL_W), .DEPTH(POSE_DEPTH)) u_pose_ram (
		.clk(clk), .we(pose_we), .waddr(pose_waddr), .wdata(value),
		.raddr(pose_raddr), .rdata(pose_rdata)
	);

	kpi_ram #(.WIDTH(FRAME_BITS), .DEPTH(DUR_DEPTH)) u_dur_ram (
		.clk(clk), .we(dur_we), .waddr(dur_waddr), .wdata(value[FRAME_BITS-1:0]),
		.raddr(dur_raddr), .rdata(dur_rdata)
	);

	kpi_ram #(.WIDTH(VAL_W), .DEPTH(REST_DEPTH)) u_rest_ram (
		.clk(clk), .we(rest_we), .waddr(rest_waddr), .wdata(value),
		.raddr(rest_raddr), .rdata(rest_rdata)
	);

	// ---------------- tick set-up terms ----------------
	logic [KCNT_W-1:0] kc_act, n_act;
	logic              is_last_act;
	logic [4:0]        k_plus;
	assign kc_act      = kcount_q[act_motion_q];
	assign n_act       = (kc_act == '0) ? KCNT_W'(1) : kc_act;
	assign k_plus      = {1'b0, act_key_q} + 5'd1;
	assign is_last_act = (k_plus >= 5'(n_act));

	// duration and clamped weight, valid in ST_DUR
	logic [FRAME_BITS-1:0] f_cur, t_cur;
	logic [FRAME_BITS:0]   tick_inc;
	assign f_cur    = (dur_rdata == '0) ? FRAME_BITS'(1) : dur_rdata;
	assign t_cur    = (tick_q < f_cur) ? tick_q : f_cur - 1'b1;
	assign tick_inc = {1'b0, tick_q} + 1'b1;

	// header count, saturated
	logic [KCNT_W-1:0] hdr_count;
	assign hdr_count = value[VAL_W-1] ? '0
		: (value > VAL_W'(KEYS)) ? KCNT_W'(KEYS) : value[KCNT_W-1:0];

	// ---------------- arithmetic ----------------
	logic signed [VAL_W-1:0]  a_q;
	logic signed [VAL_W-1:0]  rest_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     neg_q;
	logic signed [VAL_W:0]    diff;
	logic signed [VAL_W-1:0]  comp_q [NCOMP];

	assign diff = $signed(pose_rdata) - a_q;

	kpi_div_req_t div_req;
	kpi_div_rsp_t div_rsp;
	assign div_req.start    = (state_q == ST_DIVS);
	assign div_req.dividend = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : prod_q[MAG_W-1:0];
	assign div_req.divisor  = f_q;

	kpi_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// finish one component: sign, add key, rest or wrap, saturate
	logic signed [VAL_W+3:0] q_ext, v_raw, v_pos, v_rot, v_sel;
	logic signed [VAL_W-1:0] v_out;
	always_comb begin
		q_ext = $signed({3'b000, div_rsp.quotient[VAL_W:0]});
		if (neg_q) begin
			q_ext = -q_ext;
		end
		v_raw = q_ext + (VAL_W+4)'(a_q);
		v_pos = v_raw + (VAL_W+4)'(rest_q);
		if (v_raw > PI_Q) begin
			v_rot = v_raw - TWO_PI_Q;
		end else if (v_raw < -PI_Q) begin
			v_rot = v_raw + TWO_PI_Q;
		end else begin
			v_rot = v_raw;
		end
		v_sel = (int'(c_q) < COMP_ROT) ? v_pos : v_rot;
		if (v_sel > V_MAX) begin
			v_out = V_MAX[VAL_W-1:0];
		end else if (v_sel < V_MIN) begin
			v_out = V_MIN[VAL_W-1:0];
		end else begin
			v_out = v_sel[VAL_W-1:0];
		end
	end

	// ---------------- output register ----------------
	logic                    out_valid_q;
	logic                    out_free;
	logic                    out_load;
	logic                    last_part;
	logic [3:0]              out_part_q;
	logic signed [VAL_W-1:0] out_comp_q [NCOMP];
	logic                    out_last_q;
	logic                    out_fin_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_OUT) && out_free;
	assign last_part = (5'(p_q) + 5'd1 == 5'(cnt_s1));

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && kpi_kind_t'(kind) == KIND_TICK) begin
					state_d = ST_DUR;
				end
			end
			ST_DUR:  state_d = (cnt_s1 == '0) ? ST_IDLE : ST_RDA;
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIVS;
			ST_DIVS: state_d = ST_DIV;
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = (int'(c_q) == NCOMP - 1) ? ST_OUT : ST_RDA;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = last_part ? ST_IDLE : ST_RDA;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- motion state and request decode ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_motion_q <= '0;
			act_key_q    <= '0;
			tick_q       <= '0;
			done_q       <= 1'b0;
			rest_vld_q   <= '0;
			for (int i = 0; i < MOTIONS; i++) begin
				kcount_q[i] <= '0;
				loop_q[i]   <= 1'b0;
			end
		end else begin
			if (accept) begin
				case (kpi_kind_t'(kind))
					KIND_HDR: begin
						if (int'(motion) < MOTIONS) begin
							kcount_q[motion] <= hdr_count;
							loop_q[motion]   <= loop_flag;
						end
					end
					KIND_REST: begin
						if (in_range_pc) begin
							rest_vld_q[rest_waddr] <= 1'b1;
						end
					end
					KIND_SEL: begin
						if (int'(motion) < MOTIONS && motion != act_motion_q) begin
							act_motion_q <= motion;
							act_key_q    <= '0;
							tick_q       <= '0;
							done_q       <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			// advance key timing once the duration is in
			if (state_q == ST_DUR) begin
				if (tick_inc < {1'b0, f_cur}) begin
					tick_q <= tick_inc[FRAME_BITS-1:0];
					done_q <= 1'b0;
				end else if (is_last_s1) begin
					if (loop_q[m_s1]) begin
						act_key_q <= '0;
						tick_q    <= '0;
						done_q    <= 1'b0;
					end else begin
						tick_q <= f_cur - 1'b1;
						done_q <= 1'b1;
					end
				end else begin
					act_key_q <= k_s1 + 1'b1;
					tick_q    <= '0;
					done_q    <= 1'b0;
				end
			end
		end
	end

	// ---------------- tick datapath ----------------
	always_ff @(posedge clk) begin
		if (accept && kpi_kind_t'(kind) == KIND_TICK) begin
			m_s1       <= act_motion_q;
			k_s1       <= act_key_q;
			nk_s1      <= is_last_act ? 4'd0 : k_plus[3:0];
			is_last_s1 <= is_last_act;
			cnt_s1     <= (part_count_q > 5'(PARTS)) ? CNT_W'(PARTS) : part_count_q[CNT_W-1:0];
		end
		case (state_q)
			ST_DUR: begin
				f_q   <= f_cur;
				t_q   <= t_cur;
				p_q   <= '0;
				c_q   <= '0;
			end
			ST_RDB: begin
				a_q    <= $signed(pose_rdata);
				rest_q <= rest_vld_q[rest_raddr] ? $signed(rest_rdata) : '0;
			end
			ST_MUL: begin
				prod_q <= PROD_W'(diff) * $signed({1'b0, t_q});
				neg_q  <= diff[VAL_W] && (t_q != '0);
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					comp_q[c_q] <= v_out;
					c_q         <= (int'(c_q) == NCOMP - 1) ? 3'd0 : c_q + 3'd1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					p_q <= p_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// done flag already holds this tick's advance
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_part_q <= p_q;
			out_comp_q <= comp_q;
			out_last_q <= last_part;
			out_fin_q  <= done_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign part_index = out_part_q;
	assign pos_x      = out_comp_q[0];
	assign pos_y      = out_comp_q[1];
	assign pos_z      = out_comp_q[2];
	assign rot_x      = out_comp_q[3];
	assign rot_y      = out_comp_q[4];
	assign rot_z      = out_comp_q[5];
	assign last       = out_last_q;
	assign finished   = out_fin_q;

	// ---------------- assertions ----------------
	`KPI_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_q == ST_DIV)
	`KPI_ASSERT_NOW(a_comp_in_range, state_q == ST_RDA, int'(c_q) < NCOMP)
	`KPI_ASSERT_NEXT(a_last_ends_tick, out_load && last_part, state_q == ST_IDLE)
	`KPI_ASSERT_NOW(a_part_in_range, state_q == ST_OUT, 5'(p_q) < 5'(cnt_s1))

endmodule
`default_nettype wire
